/* rtl/core/text_console_cursor_writer_top_assert.svh */
// ----------------------------------------------------------------------------
// Text console cursor writer: assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console cursor writer: package
// Default geometry, op codes, item types and controller/datapath signals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int TcwRows    = 25;
  localparam int TcwCols    = 80;
  localparam int TcwScreens = 8;

  localparam logic [7:0]  NewlineCode = 8'd10;
  localparam logic [15:0] ClearValue  = 16'h0000;

  typedef enum logic [2:0] {
    OP_CHAR = 3'd0,
    OP_EOT  = 3'd1,
    OP_UP   = 3'd2,
    OP_DOWN = 3'd3,
    OP_READ = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_code;
    logic [7:0] color;
    logic       end_of_text;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0] shown_screen;
    logic [2:0] cursor_screen;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic wrap;       // apply line/screen wrap to cursor
    logic put;        // store character, advance column, end of text
    logic show;       // shown screen := cursor screen
    logic scr_up;
    logic scr_down;
    logic rd;         // issue cell read
    logic sweep;      // write one zero cell of the sweep
    logic sweep_all;  // sweep covers whole store, else cursor screen
    logic out_load;   // load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       need_clear;
    logic       all_last;
    logic       scr_last;
  } dp_status_t;

endpackage

/* rtl/core/tcw_if.sv */
// ----------------------------------------------------------------------------
// Text console cursor writer: stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcw_in_if;
  import tcw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// Text console cursor writer: controller
// Sequences reset sweep, item execution, screen clears and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_WIPE  = 6'b001000,
    ST_PUT   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  ctrl_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_SWEEP: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_all = 1'b1;
        if (status_i.all_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (status_i.op)
          OP_CHAR: begin
            cmd.wrap = 1'b1;
            state_d  = status_i.need_clear ? ST_WIPE : ST_PUT;
          end
          OP_EOT:  cmd.show     = 1'b1;
          OP_UP:   cmd.scr_up   = 1'b1;
          OP_DOWN: cmd.scr_down = 1'b1;
          OP_READ: cmd.rd       = 1'b1;
          default: ;
        endcase
      end
      ST_WIPE: begin
        cmd.sweep = 1'b1;
        if (status_i.scr_last) state_d = ST_PUT;
      end
      ST_PUT: begin
        cmd.put = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/core/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// Text console cursor writer: datapath
// Cursor and shown-screen registers, cell memory, sweep counter, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; #(
  parameter int ROWS    = TcwRows,
  parameter int COLS    = TcwCols,
  parameter int SCREENS = TcwScreens
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_data_o
);

  localparam int RowW        = $clog2(ROWS);
  localparam int ColW        = $clog2(COLS);
  localparam int ScrW        = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int ScreenCells = ROWS * COLS;
  localparam int TotalCells  = SCREENS * ScreenCells;
  localparam int AW          = $clog2(TotalCells);

  in_item_t        in_q;
  logic [ScrW-1:0] wr_scr_q;
  logic [RowW-1:0] wr_row_q;
  logic [ColW-1:0] wr_col_q;
  logic [ScrW-1:0] disp_q;
  logic            rd_ok_q;
  logic [15:0]     rdata_q;
  logic [AW-1:0]   sw_cnt_q;
  out_item_t       out_q, out_d;

  logic [15:0]     cell_mem [TotalCells];

  logic            newline, wrap_line, need_clear, in_range;
  logic [RowW-1:0] row_w;
  logic [ColW-1:0] col_w;
  logic [ScrW-1:0] scr_nx;
  logic [AW-1:0]   cur_addr, rd_addr, sw_base, sw_addr, waddr;
  logic            we;
  logic [15:0]     wdata;
  logic            all_last, scr_last;

  // cursor wrap: last column or newline ends the line
  assign newline   = (in_q.char_code == NewlineCode);
  assign wrap_line = ((wr_col_q != '0) && (wr_col_q >= ColW'(COLS - 1))) || newline;
  assign row_w     = wrap_line ? wr_row_q + 1'b1 : wr_row_q;
  assign col_w     = wrap_line ? '0 : wr_col_q;
  assign need_clear = (row_w >= RowW'(ROWS - 1));
  assign scr_nx    = (wr_scr_q == ScrW'(SCREENS - 1)) ? '0 : wr_scr_q + 1'b1;

  assign in_range = (32'(in_q.read_row) < 32'(ROWS)) && (32'(in_q.read_col) < 32'(COLS));

  assign cur_addr = AW'(wr_scr_q) * AW'(ScreenCells) + AW'(wr_row_q) * AW'(COLS)
                  + AW'(wr_col_q);
  assign rd_addr  = AW'(disp_q) * AW'(ScreenCells) + AW'(in_q.read_row) * AW'(COLS)
                  + AW'(in_q.read_col);

  assign sw_base  = cmd_i.sweep_all ? '0 : AW'(wr_scr_q) * AW'(ScreenCells);
  assign sw_addr  = sw_base + sw_cnt_q;
  assign all_last = (sw_cnt_q == AW'(TotalCells - 1));
  assign scr_last = (sw_cnt_q == AW'(ScreenCells - 1));

  assign we    = cmd_i.sweep || (cmd_i.put && !newline);
  assign waddr = cmd_i.sweep ? sw_addr : cur_addr;
  assign wdata = cmd_i.sweep ? ClearValue : {in_q.color, in_q.char_code};

  always_ff @(posedge clk_i) begin
    if (we) cell_mem[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_scr_q <= '0;
      wr_row_q <= '0;
      wr_col_q <= '0;
      disp_q   <= '0;
      rd_ok_q  <= 1'b0;
      sw_cnt_q <= '0;
    end else begin
      if (cmd_i.wrap) begin
        if (need_clear) begin
          wr_scr_q <= scr_nx;
          wr_row_q <= '0;
          wr_col_q <= '0;
        end else begin
          wr_row_q <= row_w;
          wr_col_q <= col_w;
        end
      end else if (cmd_i.put && !newline) begin
        wr_col_q <= wr_col_q + 1'b1;
      end

      if ((cmd_i.put && in_q.end_of_text) || cmd_i.show) begin
        disp_q <= wr_scr_q;
      end else if (cmd_i.scr_up && (disp_q != '0)) begin
        disp_q <= disp_q - 1'b1;
      end else if (cmd_i.scr_down && (disp_q != ScrW'(SCREENS - 1))) begin
        disp_q <= disp_q + 1'b1;
      end

      if (cmd_i.rd) rd_ok_q <= in_range;

      if (cmd_i.sweep) begin
        if ((cmd_i.sweep_all && all_last) || (!cmd_i.sweep_all && scr_last)) begin
          sw_cnt_q <= '0;
        end else begin
          sw_cnt_q <= sw_cnt_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_d.shown_screen  = 3'(disp_q);
    out_d.cursor_screen = 3'(wr_scr_q);
    out_d.cursor_row    = 5'(wr_row_q);
    out_d.cursor_col    = 7'(wr_col_q);
    if ((in_q.op == OP_READ) && rd_ok_q) begin
      out_d.cell_char  = rdata_q[7:0];
      out_d.cell_color = rdata_q[15:8];
    end else begin
      out_d.cell_char  = '0;
      out_d.cell_color = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign status_o.op         = in_q.op;
  assign status_o.need_clear = need_clear;
  assign status_o.all_last   = all_last;
  assign status_o.scr_last   = scr_last;
  assign out_data_o          = out_q;

endmodule

/* rtl/core/text_console_cursor_writer_top.sv */
// ----------------------------------------------------------------------------
// Text console cursor writer: top level
// Sequencing: a character passes IDLE, EXEC, PUT and DONE, other items IDLE,
//   EXEC and DONE; result valid is registered from DONE. A character that moves
//   the cursor to a new screen also passes WIPE to clear that screen through
//   the memory write port. A new item is taken only once the last result is
//   loaded into the result register; a result may wait while the next item is
//   taken.
// Reset: cursor, shown screen and handshakes clear at once; then a clearing
//   pass over the whole store zeroes it with ready held low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_writer_top import tcw_pkg::*; #(
  parameter int ROWS    = TcwRows,
  parameter int COLS    = TcwCols,
  parameter int SCREENS = TcwScreens
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcw_in_if.sink   item_i,
  tcw_out_if.source result_o
);

  // Controller and datapath talk only through these two groups.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Controller: reset sweep, item sequencing, result register hand-off.
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: cursor state, cell memory and the result register.
  tcw_datapath #(
    .ROWS    (ROWS),
    .COLS    (COLS),
    .SCREENS (SCREENS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (item_i.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (result_o.data)
  );

endmodule

/* rtl/core/tcw_checker.sv */
// ----------------------------------------------------------------------------
// Text console cursor writer: port checker
// Watches the top-level channels for result hold, ranges and item accounting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_cursor_writer_top_assert.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int ROWS    = TcwRows,
  parameter int COLS    = TcwCols,
  parameter int SCREENS = TcwScreens
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items taken in whose result has not yet been taken out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `TCW_ASSERT_NXT(a_result_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(out_data_i), "result dropped or changed while stalled")

  `TCW_ASSERT_IMP(a_result_range, clk_i, rst_ni, out_valid_i,
                  (32'(out_data_i.shown_screen) < 32'(SCREENS)) &&
                  (32'(out_data_i.cursor_screen) < 32'(SCREENS)) &&
                  (32'(out_data_i.cursor_row) < 32'(ROWS - 1)) &&
                  (32'(out_data_i.cursor_col) < 32'(COLS)), "result field out of range")

  `TCW_ASSERT_IMP(a_no_orphan, clk_i, rst_ni, out_valid_i, pend_q != 2'd0,
                  "result shown with no item outstanding")

  `TCW_ASSERT_IMP(a_one_ahead, clk_i, rst_ni, in_acc, pend_q <= 2'd1,
                  "item accepted with two results outstanding")

endmodule

bind text_console_cursor_writer_top tcw_checker #(
  .ROWS    (ROWS),
  .COLS    (COLS),
  .SCREENS (SCREENS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
